>>> hw/rtl/cdec_pkg.sv
// Shared types, codes and helpers for the mouse event click decoder.
// Used by every module of the decoder.
package cdec_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int MAX_RES         = 3;
  localparam int CNT_W           = 2;

  localparam logic [1:0] CMD_AXIS   = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam logic [1:0] AXIS_WHEEL = 2'd2;

  localparam logic [2:0] EV_DOWN   = 3'd0;
  localparam logic [2:0] EV_UP     = 3'd1;
  localparam logic [2:0] EV_CLICK  = 3'd2;
  localparam logic [2:0] EV_DOUBLE = 3'd3;
  localparam logic [2:0] EV_MOVE   = 3'd4;
  localparam logic [2:0] EV_SCROLL = 3'd5;

  localparam logic [7:0]  PRESS_MASK   = 8'h80;
  localparam logic [15:0] THRESH_RESET = 16'd250;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         axis;
    logic signed [15:0] delta;
    logic [2:0]         button;
    logic [7:0]         button_data;
    logic [31:0]        now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [2:0]         event_button;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_wheel;
    logic [7:0]         pressed_mask;
    logic               last;
  } evt_t;

  // All results caused by one input item, in delivery order from slot 0.
  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    evt_t [MAX_RES-1:0]    ev;
  } bundle_t;

  function automatic evt_t mk_evt(input logic [2:0] res, input logic [2:0] btn,
                                  input logic [31:0] mx, input logic [31:0] my,
                                  input logic [31:0] mw, input logic [7:0] mask,
                                  input logic lst);
    evt_t e;
    e.event_res    = res;
    e.event_button = btn;
    e.move_x       = mx;
    e.move_y       = my;
    e.move_wheel   = mw;
    e.pressed_mask = mask;
    e.last         = lst;
    return e;
  endfunction

endpackage

>>> hw/rtl/cdec_if.sv
// Valid/ready channel interfaces of the mouse event click decoder.
// Depends on cdec_pkg for nothing but is compiled after it.
interface cdec_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [1:0]         axis;
  logic signed [15:0] delta;
  logic [2:0]         button;
  logic [7:0]         button_data;
  logic [31:0]        now;
  modport source (output valid, cmd, axis, delta, button, button_data, now, input ready);
  modport sink   (input valid, cmd, axis, delta, button, button_data, now, output ready);
endinterface

interface cdec_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic [2:0]         event_button;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_wheel;
  logic [7:0]         pressed_mask;
  logic               last;
  modport source (output valid, event_res, event_button, move_x, move_y, move_wheel,
                  pressed_mask, last, input ready);
  modport sink   (input valid, event_res, event_button, move_x, move_y, move_wheel,
                  pressed_mask, last, output ready);
endinterface

interface cdec_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] click_threshold;
  modport source (output valid, click_threshold, input ready);
  modport sink   (input valid, click_threshold, output ready);
endinterface

>>> hw/rtl/cdec_evt_gen.sv
// Decoder state (accumulators, button flags, timestamps) and the logic that
// turns one registered input item into a bundle of results. Uses cdec_pkg.
module cdec_evt_gen #(
  parameter int NUM_BUTTONS = cdec_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cdec_pkg::in_item_t item,
  input  logic               step,
  input  logic [15:0]        thresh,
  output cdec_pkg::bundle_t  bundle
);

  localparam int BIDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [31:0]            acc_x_r, acc_x_nxt;
  logic [31:0]            acc_y_r, acc_y_nxt;
  logic [31:0]            acc_w_r, acc_w_nxt;
  logic [NUM_BUTTONS-1:0] flags_r, flags_nxt;
  logic [31:0]            down_time_r  [NUM_BUTTONS];
  logic [31:0]            click_time_r [NUM_BUTTONS];

  logic [BIDX_W-1:0] bidx;
  logic              btn_ok;
  logic              press;
  logic              click;
  logic              dbl;
  logic              mv;
  logic              sc;
  logic [31:0]       thr32;
  logic [7:0]        mask;
  logic [31:0]       dlt32;

  assign bidx   = item.button[BIDX_W-1:0];
  assign btn_ok = 32'(item.button) < NUM_BUTTONS;
  assign press  = (item.button_data & cdec_pkg::PRESS_MASK) != 8'd0;
  assign thr32  = 32'(thresh);
  assign dlt32  = 32'(item.delta);
  // Only a button release can be a click; other commands leave the click times alone.
  assign click  = (item.cmd == cdec_pkg::CMD_BUTTON) && btn_ok && !press &&
                  ((item.now - down_time_r[bidx]) < thr32);
  assign dbl    = click && ((item.now - click_time_r[bidx]) < thr32);
  assign mv     = (acc_x_r != 32'd0) || (acc_y_r != 32'd0);
  assign sc     = acc_w_r != 32'd0;
  assign mask   = 8'(flags_nxt);

  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    acc_w_nxt = acc_w_r;
    flags_nxt = flags_r;
    bundle    = '0;
    case (item.cmd)
      cdec_pkg::CMD_AXIS: begin
        case (item.axis)
          cdec_pkg::AXIS_X:     acc_x_nxt = acc_x_r + dlt32;
          cdec_pkg::AXIS_Y:     acc_y_nxt = acc_y_r + dlt32;
          cdec_pkg::AXIS_WHEEL: acc_w_nxt = acc_w_r + dlt32;
          default: ;
        endcase
      end
      cdec_pkg::CMD_BUTTON: begin
        if (btn_ok) begin
          flags_nxt[bidx] = press;
        end
      end
      cdec_pkg::CMD_END: begin
        acc_x_nxt = '0;
        acc_y_nxt = '0;
        acc_w_nxt = '0;
      end
      default: ;
    endcase

    // Results are packed from slot 0 so that the output side can walk them.
    if (item.cmd == cdec_pkg::CMD_BUTTON && btn_ok) begin
      if (press) begin
        bundle.cnt   = 2'd1;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_DOWN, item.button, '0, '0, '0, mask, 1'b1);
      end else if (dbl) begin
        bundle.cnt   = 2'd3;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_DOUBLE, item.button, '0, '0, '0, mask, 1'b0);
        bundle.ev[1] = cdec_pkg::mk_evt(cdec_pkg::EV_CLICK, item.button, '0, '0, '0, mask, 1'b0);
        bundle.ev[2] = cdec_pkg::mk_evt(cdec_pkg::EV_UP, item.button, '0, '0, '0, mask, 1'b1);
      end else if (click) begin
        bundle.cnt   = 2'd2;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_CLICK, item.button, '0, '0, '0, mask, 1'b0);
        bundle.ev[1] = cdec_pkg::mk_evt(cdec_pkg::EV_UP, item.button, '0, '0, '0, mask, 1'b1);
      end else begin
        bundle.cnt   = 2'd1;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_UP, item.button, '0, '0, '0, mask, 1'b1);
      end
    end else if (item.cmd == cdec_pkg::CMD_END) begin
      if (mv && sc) begin
        bundle.cnt   = 2'd2;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_MOVE, 3'd0, acc_x_r, acc_y_r, '0, mask, 1'b0);
        bundle.ev[1] = cdec_pkg::mk_evt(cdec_pkg::EV_SCROLL, 3'd0, '0, '0, acc_w_r, mask, 1'b1);
      end else if (mv) begin
        bundle.cnt   = 2'd1;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_MOVE, 3'd0, acc_x_r, acc_y_r, '0, mask, 1'b1);
      end else if (sc) begin
        bundle.cnt   = 2'd1;
        bundle.ev[0] = cdec_pkg::mk_evt(cdec_pkg::EV_SCROLL, 3'd0, '0, '0, acc_w_r, mask, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_w_r <= '0;
      flags_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        down_time_r[i]  <= '0;
        click_time_r[i] <= '0;
      end
    end else if (step) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      acc_w_r <= acc_w_nxt;
      flags_r <= flags_nxt;
      if (item.cmd == cdec_pkg::CMD_BUTTON && btn_ok && press) begin
        down_time_r[bidx] <= item.now;
      end
      if (click) begin
        click_time_r[bidx] <= item.now;
      end
    end
  end

endmodule

>>> hw/rtl/cdec_out_buf.sv
// Result register that holds one bundle and hands its results out one per
// transfer, slot 0 first. Uses cdec_pkg types.
module cdec_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cdec_pkg::bundle_t bundle,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output cdec_pkg::evt_t    out_evt
);

  logic                       vld_r;
  cdec_pkg::bundle_t          bnd_r;
  logic [cdec_pkg::CNT_W-1:0] idx_r;
  logic                       take;

  assign out_valid = vld_r;
  assign out_evt   = bnd_r.ev[idx_r];
  assign take      = vld_r && out_ready;
  // Free when empty, or when the final result is being taken this cycle.
  assign free      = !vld_r || (take && out_evt.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (take) begin
      if (out_evt.last) begin
        vld_r <= 1'b0;
      end
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bundle;
    end
  end

endmodule

>>> hw/rtl/mouse_event_click_decoder_core.sv
// Mouse event click decoder: accepts one mouse event per cycle into an input
// register, for items with one result or none while the output does not stall;
// a single pass of logic updates the accumulators, button flags and timestamps
// and loads up to three results into the result register, which hands them out
// one per transfer; an item with n results holds it for n output transfers. The
// click threshold resets to 250 ms; the user must write it through the cfg
// channel only while idle, not enforced by the block. Uses cdec_pkg and cdec_if.
module mouse_event_click_decoder_core #(
  parameter int NUM_BUTTONS = cdec_pkg::NUM_BUTTONS_DEF
) (
  input logic   clk,
  input logic   rst_n,
  cdec_in_if.sink    in_ch,
  cdec_out_if.source out_ch,
  cdec_cfg_if.sink   cfg_ch
);

  logic               in_vld_r;
  cdec_pkg::in_item_t in_item_r;
  logic [15:0]        thresh_r;
  cdec_pkg::bundle_t  bundle;
  cdec_pkg::evt_t     out_evt;
  logic               buf_free;
  logic               adv;
  logic               load;

  assign adv          = in_vld_r && (buf_free || bundle.cnt == '0);
  assign load         = adv && bundle.cnt != '0;
  assign in_ch.ready  = !in_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      thresh_r <= cdec_pkg::THRESH_RESET;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (cfg_ch.valid) begin
        thresh_r <= cfg_ch.click_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.cmd         <= in_ch.cmd;
      in_item_r.axis        <= in_ch.axis;
      in_item_r.delta       <= in_ch.delta;
      in_item_r.button      <= in_ch.button;
      in_item_r.button_data <= in_ch.button_data;
      in_item_r.now         <= in_ch.now;
    end
  end

  cdec_evt_gen #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_item_r),
    .step   (adv),
    .thresh (thresh_r),
    .bundle (bundle)
  );

  cdec_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .free      (buf_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_evt   (out_evt)
  );

  assign out_ch.event_res    = out_evt.event_res;
  assign out_ch.event_button = out_evt.event_button;
  assign out_ch.move_x       = out_evt.move_x;
  assign out_ch.move_y       = out_evt.move_y;
  assign out_ch.move_wheel   = out_evt.move_wheel;
  assign out_ch.pressed_mask = out_evt.pressed_mask;
  assign out_ch.last         = out_evt.last;

  // A bundle is never cut short: a result without last is followed by another.
  a_bundle_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("result bundle ended without last");

  // A waiting input item blocks the input channel.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |-> !in_ch.ready)
    else $error("input accepted over a held item");

  // Down shows its button pressed; up shows it released.
  a_mask_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res == cdec_pkg::EV_DOWN)
      |-> out_ch.pressed_mask[out_ch.event_button])
    else $error("down event without pressed flag");

  a_mask_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res == cdec_pkg::EV_UP)
      |-> !out_ch.pressed_mask[out_ch.event_button])
    else $error("up event with pressed flag");

endmodule
